[sv/tlpq_pkg.sv]
// shared types, codes and register constants for the touch long-press qualifier
package tlpq_pkg;

    // event codes
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;

    // application modes
    localparam logic [1:0] MODE_PERF  = 2'd0;
    localparam logic [1:0] MODE_SAVER = 2'd1;
    localparam logic [1:0] MODE_PROG  = 2'd2;

    // the one pad that acts
    localparam logic [3:0] PAD_ID = 4'd12;

    // configuration register indexes
    localparam logic [2:0] REG_LONG_PRESS = 3'd0;
    localparam logic [2:0] REG_ELEV_THR   = 3'd1;
    localparam logic [2:0] REG_SHORT_MIN  = 3'd2;
    localparam logic [2:0] REG_BOOT_GRACE = 3'd3;
    localparam logic [2:0] REG_POLL_STEP  = 3'd4;

    // configuration reset values
    localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [21:0] ELEV_THR_RST   = 22'd0;
    localparam logic [15:0] SHORT_MIN_RST  = 16'd75;
    localparam logic [15:0] BOOT_GRACE_RST = 16'd8000;
    localparam logic [9:0]  POLL_STEP_RST  = 10'd100;

    localparam int APB_ADDR_W = 5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  pad_number;
        logic [1:0]  app_mode;
        logic        switch_pressed;
        logic        reading_valid;
        logic [21:0] smooth_reading;
        logic [21:0] bench_reading;
        logic [21:0] baseline_reading;
        logic [31:0] time_ms;
        logic        calib_busy;
    } in_word_t;

    typedef struct packed {
        logic hold_active;
        logic long_press_fired;
        logic back_request;
        logic recover_request;
        logic armed;
    } out_word_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [21:0] elev_threshold;
        logic [15:0] short_press_min_ms;
        logic [15:0] boot_grace_ms;
        logic [9:0]  poll_step_ms;
    } cfg_t;

endpackage

[sv/touch_long_press_qualifier.sv]
// top level of the touch long-press qualifier
//
//  channel   ports                      word
//  input     s_valid s_ready s_data     event (press, release, poll)
//  result    m_valid m_ready m_data     hold, pulses and armed level
//  config    psel penable pwrite paddr  five registers at 4*i
//
// one word per cycle while the result is taken; input register, then result register
// state updates as a word moves into the result register, so back-to-back words chain
// a stalled result holds, and one more word waits in the input register
// reset is synchronous on aresetn low; configuration returns to its defaults
module touch_long_press_qualifier (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tlpq_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tlpq_pkg::out_word_t            m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tlpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tlpq_pkg::*;

    cfg_t     cfg;
    logic     ev_valid;
    logic     ev_take;
    in_word_t ev_data;

    // configuration registers
    tlpq_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    tlpq_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .ev_valid (ev_valid),
        .ev_data  (ev_data),
        .ev_take  (ev_take)
    );

    // qualification logic and result register
    tlpq_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .ev_valid (ev_valid),
        .ev_data  (ev_data),
        .ev_take  (ev_take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // polling never runs without the hold indication
    a_armed_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.armed |-> m_data.hold_active)
        else $error("armed without hold");

    // a fired long press stops polling and keeps the hold level
    a_fire_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.long_press_fired |-> !m_data.armed && m_data.hold_active)
        else $error("fire left polling running");

    // back only comes from a release, so never alongside recover or fire
    a_pulse_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.back_request |-> !m_data.recover_request
            && !m_data.long_press_fired && !m_data.hold_active)
        else $error("back overlaps another pulse");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

[sv/tlpq_cfg_regs.sv]
// configuration register file behind the apb port
module tlpq_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tlpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tlpq_pkg::cfg_t                 cfg
);
    import tlpq_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms      <= LONG_PRESS_RST;
            cfg_reg.elev_threshold     <= ELEV_THR_RST;
            cfg_reg.short_press_min_ms <= SHORT_MIN_RST;
            cfg_reg.boot_grace_ms      <= BOOT_GRACE_RST;
            cfg_reg.poll_step_ms       <= POLL_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LONG_PRESS: cfg_reg.long_press_ms      <= pwdata[15:0];
                REG_ELEV_THR:   cfg_reg.elev_threshold     <= pwdata[21:0];
                REG_SHORT_MIN:  cfg_reg.short_press_min_ms <= pwdata[15:0];
                REG_BOOT_GRACE: cfg_reg.boot_grace_ms      <= pwdata[15:0];
                REG_POLL_STEP:  cfg_reg.poll_step_ms       <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ms};
            REG_ELEV_THR:   prdata = {10'd0, cfg_reg.elev_threshold};
            REG_SHORT_MIN:  prdata = {16'd0, cfg_reg.short_press_min_ms};
            REG_BOOT_GRACE: prdata = {16'd0, cfg_reg.boot_grace_ms};
            REG_POLL_STEP:  prdata = {22'd0, cfg_reg.poll_step_ms};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

[sv/tlpq_in_stage.sv]
// input register stage for event words
module tlpq_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tlpq_pkg::in_word_t s_data,
    output logic               ev_valid,
    output tlpq_pkg::in_word_t ev_data,
    input  logic               ev_take
);
    import tlpq_pkg::*;

    logic     valid_reg;
    in_word_t data_reg;

    assign s_ready  = !valid_reg || ev_take;
    assign ev_valid = valid_reg;
    assign ev_data  = data_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

endmodule

[sv/tlpq_core.sv]
// press qualification state, next-state logic and result register
module tlpq_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  tlpq_pkg::cfg_t      cfg,
    input  logic                ev_valid,
    input  tlpq_pkg::in_word_t  ev_data,
    output logic                ev_take,
    output logic                m_valid,
    input  logic                m_ready,
    output tlpq_pkg::out_word_t m_data
);
    import tlpq_pkg::*;

    logic        armed_reg, armed_next;
    logic        fired_reg, fired_next;
    logic        hold_reg, hold_next;
    logic [16:0] accum_reg, accum_next;
    logic [31:0] start_reg, start_next;
    logic        out_valid_reg;
    out_word_t   out_reg, out_next;

    logic        perf_like;
    logic        pad_hit;
    logic        elevated;
    logic        collapsed;
    logic [21:0] elev_diff;
    logic [23:0] base_x3;
    logic [16:0] accum_sum;
    logic [31:0] duration;
    logic        fire, back, recover;

    assign ev_take = ev_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // shared compares
    always_comb begin
        perf_like = (ev_data.app_mode == MODE_PERF) || (ev_data.app_mode == MODE_SAVER);
        pad_hit   = ev_data.pad_number == PAD_ID;
        elev_diff = ev_data.smooth_reading - ev_data.baseline_reading;
        elevated  = ev_data.reading_valid && (ev_data.baseline_reading != 22'd0)
                    && (ev_data.smooth_reading > ev_data.baseline_reading)
                    && (elev_diff > cfg.elev_threshold);
        base_x3   = {2'd0, ev_data.baseline_reading} + {1'b0, ev_data.baseline_reading, 1'b0};
        collapsed = ev_data.reading_valid && (ev_data.baseline_reading != 22'd0)
                    && (ev_data.bench_reading < base_x3[23:2]);
        accum_sum = accum_reg + {7'd0, cfg.poll_step_ms};
        duration  = ev_data.time_ms - start_reg;
    end

    // event handling
    always_comb begin
        armed_next = armed_reg;
        fired_next = fired_reg;
        hold_next  = hold_reg;
        accum_next = accum_reg;
        start_next = start_reg;
        fire       = 1'b0;
        back       = 1'b0;
        recover    = 1'b0;
        case (ev_data.opcode)
            OP_PRESS: begin
                if (pad_hit) begin
                    start_next = ev_data.time_ms;
                    if (perf_like) begin
                        if (elevated) begin
                            fired_next = 1'b0;
                            accum_next = 17'd0;
                            hold_next  = 1'b1;
                            armed_next = 1'b1;
                        end else begin
                            recover = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (pad_hit) begin
                    accum_next = 17'd0;
                    hold_next  = 1'b0;
                    armed_next = 1'b0;
                    if (ev_data.app_mode == MODE_PROG && !ev_data.calib_busy) begin
                        if (fired_reg) begin
                            fired_next = 1'b0;
                        end else if (duration >= {16'd0, cfg.short_press_min_ms}) begin
                            back = 1'b1;
                        end
                    end
                end
            end
            OP_POLL: begin
                if (armed_reg) begin
                    if (!perf_like || (ev_data.time_ms < {16'd0, cfg.boot_grace_ms})
                            || !ev_data.switch_pressed || !elevated) begin
                        // abort; recovery only when the benchmark collapsed
                        accum_next = 17'd0;
                        hold_next  = 1'b0;
                        armed_next = 1'b0;
                        recover    = perf_like && (ev_data.time_ms >= {16'd0, cfg.boot_grace_ms})
                                     && ev_data.switch_pressed && collapsed;
                    end else begin
                        accum_next = accum_sum;
                        if (accum_sum >= {1'b0, cfg.long_press_ms}) begin
                            armed_next = 1'b0;
                            fired_next = 1'b1;
                            fire       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        out_next.hold_active      = hold_next;
        out_next.long_press_fired = fire;
        out_next.back_request     = back;
        out_next.recover_request  = recover;
        out_next.armed            = armed_next;
    end

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b0;
            fired_reg     <= 1'b0;
            hold_reg      <= 1'b0;
            accum_reg     <= 17'd0;
            start_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ev_take) begin
                armed_reg <= armed_next;
                fired_reg <= fired_next;
                hold_reg  <= hold_next;
                accum_reg <= accum_next;
                start_reg <= start_next;
            end
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= ev_valid;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (ev_take) begin
            out_reg <= out_next;
        end
    end

endmodule

[tb/sv/tb_touch_long_press_qualifier.sv]
// self-checking testbench for the touch long-press qualifier with its own event predictor
module tb_touch_long_press_qualifier;
    import tlpq_pkg::*;

    // codes with no name in the package
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int unsigned READING_MAX = 32'h003F_FFFF;
    localparam int unsigned TIMEOUT_UNITS = 2_000_000;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #2 aclk = ~aclk;

    // block ports
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    touch_long_press_qualifier DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus and scoreboard storage
    in_word_t    event_queue[$];
    out_word_t   expected_levels[$];
    int unsigned error_count = 0;
    int unsigned stim_count = 0;
    logic        idle_on = 1'b1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    // stimulus-side view of the configuration
    cfg_t        plan;
    int unsigned now_ms;

    // predictor state and its copy of the configuration
    cfg_t        cfg_copy;
    logic        armed_r;
    logic        fired_r;
    logic        hold_r;
    logic [16:0] accum_r;
    logic [31:0] press_t0;
    out_word_t   want;

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_bit(input string field, input logic got, input logic wanted);
        if (got !== wanted)
            log_mismatch($sformatf("%s got %b expected %b", field, got, wanted));
    endtask

    // next result levels for one event word, advancing the predictor state
    function automatic out_word_t qualify_event(input in_word_t ev);
        out_word_t r;
        logic perf_like, touch_hit, collapsed;
        r = '0;
        perf_like = (ev.app_mode == MODE_PERF) || (ev.app_mode == MODE_SAVER);
        touch_hit = ev.reading_valid && (ev.baseline_reading != '0) &&
                    (ev.smooth_reading > ev.baseline_reading) &&
                    ((ev.smooth_reading - ev.baseline_reading) > cfg_copy.elev_threshold);
        collapsed = ev.reading_valid && (ev.baseline_reading != '0) &&
                    ({2'b00, ev.bench_reading} < (({2'b00, ev.baseline_reading} * 24'd3) / 24'd4));
        if (ev.opcode == OP_PRESS && ev.pad_number == PAD_ID) begin
            press_t0 = ev.time_ms;
            if (perf_like) begin
                if (touch_hit) begin
                    fired_r = 1'b0;
                    accum_r = '0;
                    hold_r = 1'b1;
                    armed_r = 1'b1;
                end else begin
                    r.recover_request = 1'b1;
                end
            end
        end else if (ev.opcode == OP_RELEASE && ev.pad_number == PAD_ID) begin
            accum_r = '0;
            hold_r = 1'b0;
            armed_r = 1'b0;
            if (ev.app_mode == MODE_PROG && !ev.calib_busy) begin
                if (fired_r)
                    fired_r = 1'b0;
                else if ((ev.time_ms - press_t0) >= {16'd0, cfg_copy.short_press_min_ms})
                    r.back_request = 1'b1;
            end
        end else if (ev.opcode == OP_POLL && armed_r) begin
            if (!perf_like || ev.time_ms < {16'd0, cfg_copy.boot_grace_ms} ||
                !ev.switch_pressed) begin
                accum_r = '0;
                hold_r = 1'b0;
                armed_r = 1'b0;
            end else if (!touch_hit) begin
                accum_r = '0;
                hold_r = 1'b0;
                armed_r = 1'b0;
                r.recover_request = collapsed;
            end else begin
                accum_r = accum_r + {7'd0, cfg_copy.poll_step_ms};
                if (accum_r >= {1'b0, cfg_copy.long_press_ms}) begin
                    armed_r = 1'b0;
                    fired_r = 1'b1;
                    r.long_press_fired = 1'b1;
                end
            end
        end
        r.hold_active = hold_r;
        r.armed = armed_r;
        return r;
    endfunction

    // input driver: one word from the queue at a time, with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (event_queue.size() != 0) begin
                s_data <= event_queue.pop_front();
                s_valid <= 1'b1;
                if (idle_on && $urandom_range(7, 0) == 0)
                    gap_left <= $urandom_range(19, 1);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor, receiver stalls and predictor bookkeeping
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
            cfg_copy.long_press_ms = LONG_PRESS_RST;
            cfg_copy.elev_threshold = ELEV_THR_RST;
            cfg_copy.short_press_min_ms = SHORT_MIN_RST;
            cfg_copy.boot_grace_ms = BOOT_GRACE_RST;
            cfg_copy.poll_step_ms = POLL_STEP_RST;
            armed_r = 1'b0;
            fired_r = 1'b0;
            hold_r = 1'b0;
            accum_r = '0;
            press_t0 = '0;
        end else begin
            // receiver stall bursts
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_on && $urandom_range(9, 0) == 0) begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(18, 0);
            end else begin
                m_ready <= 1'b1;
            end

            // check the accepted result word against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    log_mismatch("result word with nothing expected");
                end else begin
                    want = expected_levels.pop_front();
                    compare_bit("hold_active", m_data.hold_active, want.hold_active);
                    compare_bit("long_press_fired", m_data.long_press_fired,
                                want.long_press_fired);
                    compare_bit("back_request", m_data.back_request, want.back_request);
                    compare_bit("recover_request", m_data.recover_request,
                                want.recover_request);
                    compare_bit("armed", m_data.armed, want.armed);
                end
            end

            // predict the accepted event word
            if (s_valid && s_ready)
                expected_levels.push_back(qualify_event(s_data));

            // register writes seen on the bus
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LONG_PRESS: cfg_copy.long_press_ms = pwdata[15:0];
                    REG_ELEV_THR:   cfg_copy.elev_threshold = pwdata[21:0];
                    REG_SHORT_MIN:  cfg_copy.short_press_min_ms = pwdata[15:0];
                    REG_BOOT_GRACE: cfg_copy.boot_grace_ms = pwdata[15:0];
                    REG_POLL_STEP:  cfg_copy.poll_step_ms = pwdata[9:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config(input cfg_t c);
        plan = c;
        apb_write(REG_LONG_PRESS, {16'd0, c.long_press_ms});
        apb_write(REG_ELEV_THR, {10'd0, c.elev_threshold});
        apb_write(REG_SHORT_MIN, {16'd0, c.short_press_min_ms});
        apb_write(REG_BOOT_GRACE, {16'd0, c.boot_grace_ms});
        apb_write(REG_POLL_STEP, {22'd0, c.poll_step_ms});
    endtask

    // sender holds off until every expected result has come back
    task automatic wait_idle();
        do @(negedge aclk);
        while (event_queue.size() != 0 || s_valid || expected_levels.size() != 0);
    endtask

    task automatic queue_word(input in_word_t ev);
        event_queue.push_back(ev);
        stim_count++;
    endtask

    // pad 12 event at the current time, readings elevated or not, benchmark sunk or not
    function automatic in_word_t build_event(input logic [1:0] op, input logic [1:0] mode,
                                             input logic touch, input logic sunk);
        in_word_t ev;
        int unsigned thr, room, base, smooth, bench, hi;
        thr = plan.elev_threshold;
        room = READING_MAX - thr;
        if (room >= 2)
            base = $urandom_range(room - 1, 1);
        else
            base = $urandom_range(READING_MAX, 1);
        if (touch && room >= 2) begin
            smooth = base + thr + $urandom_range(room - base, 1);
        end else begin
            hi = base + thr;
            if (hi > READING_MAX)
                hi = READING_MAX;
            smooth = $urandom_range(hi, 0);
        end
        if (sunk && base >= 2)
            bench = $urandom_range((base * 3) / 4 - 1, 0);
        else
            bench = $urandom_range(READING_MAX, (base * 3) / 4);
        ev.opcode = op;
        ev.pad_number = PAD_ID;
        ev.app_mode = mode;
        ev.switch_pressed = 1'b1;
        ev.reading_valid = 1'b1;
        ev.smooth_reading = 22'(smooth);
        ev.bench_reading = 22'(bench);
        ev.baseline_reading = 22'(base);
        ev.time_ms = now_ms;
        ev.calib_busy = 1'($urandom);
        return ev;
    endfunction

    // fully random word, mostly ignored pads and codes
    task automatic push_noise();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        event_queue.push_back(raw[$bits(in_word_t)-1:0]);
    endtask

    // press, a run of polls with the odd broken one, then a release
    task automatic push_hold_sequence();
        in_word_t ev;
        logic [1:0] mode, rel_mode;
        int unsigned r, need, polls, k;
        r = $urandom_range(9, 0);
        if (r < 7)
            mode = r[0] ? MODE_SAVER : MODE_PERF;
        else if (r < 9)
            mode = MODE_PROG;
        else
            mode = MODE_NONE;
        now_ms += $urandom_range(500, 1);
        queue_word(build_event(OP_PRESS, mode, $urandom_range(9, 0) != 0, 1'b0));

        need = (plan.long_press_ms + plan.poll_step_ms - 1) / plan.poll_step_ms;
        if (READING_MAX - plan.elev_threshold < 2)
            need = 0;
        polls = $urandom_range(need + 2, 0);
        for (k = 0; k < polls; k++) begin
            now_ms += $urandom_range(150, 1);
            ev = build_event(OP_POLL, mode, 1'b1, 1'b0);
            ev.pad_number = 4'($urandom);
            ev.calib_busy = 1'($urandom);
            case ($urandom_range(29, 0))
                0: ev.switch_pressed = 1'b0;
                1: ev = build_event(OP_POLL, mode, 1'b0, 1'($urandom));
                2: ev.app_mode = $urandom_range(1, 0) ? MODE_PROG : MODE_NONE;
                3: ev.reading_valid = 1'b0;
                4: ev.time_ms = $urandom_range(plan.boot_grace_ms, 0);
                5: ev.baseline_reading = '0;
                default: ;
            endcase
            queue_word(ev);
        end

        now_ms += $urandom_range(2 * plan.short_press_min_ms + 20, 0);
        r = $urandom_range(9, 0);
        if (r < 6)
            rel_mode = MODE_PROG;
        else if (r == 6)
            rel_mode = MODE_PERF;
        else if (r == 7)
            rel_mode = MODE_SAVER;
        else if (r == 8)
            rel_mode = MODE_NONE;
        else
            rel_mode = mode;
        ev = build_event(OP_RELEASE, rel_mode, 1'($urandom), 1'($urandom));
        ev.calib_busy = ($urandom_range(4, 0) == 0);
        queue_word(ev);
    endtask

    task automatic run_phase(input cfg_t c, input int unsigned quota, input logic pause_mid,
                             input logic near_wrap);
        int unsigned goal;
        wait_idle();
        load_config(c);
        if (near_wrap)
            now_ms = 32'hFFFF_FFFF - $urandom_range(20000, 0);
        else
            now_ms = $urandom_range(32'hFFF0_0000, 32'h0002_0000);
        goal = stim_count + quota;
        while (stim_count < goal) begin
            if (pause_mid && stim_count >= goal - quota / 2) begin
                wait_idle();
                pause_mid = 1'b0;
            end
            if ($urandom_range(9, 0) == 0)
                push_noise();
            else
                push_hold_sequence();
        end
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.long_press_ms = 16'($urandom_range(3000, 0));
        c.elev_threshold = 22'($urandom_range(20000, 0));
        c.short_press_min_ms = 16'($urandom_range(500, 0));
        c.boot_grace_ms = 16'($urandom);
        c.poll_step_ms = 10'($urandom_range(1000, 50));
        return c;
    endfunction

    // main sequence
    initial begin
        in_word_t ev;
        cfg_t c;
        plan.long_press_ms = LONG_PRESS_RST;
        plan.elev_threshold = ELEV_THR_RST;
        plan.short_press_min_ms = SHORT_MIN_RST;
        plan.boot_grace_ms = BOOT_GRACE_RST;
        plan.poll_step_ms = POLL_STEP_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: arm, one step, release too short for back
        now_ms = 32'd10000;
        queue_word(build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0));
        now_ms = 32'd10040;
        queue_word(build_event(OP_POLL, MODE_PERF, 1'b1, 1'b0));
        now_ms = 32'd10050;
        queue_word(build_event(OP_RELEASE, MODE_PROG, 1'b0, 1'b0));
        wait_idle();

        c.long_press_ms = 16'd300;
        c.elev_threshold = 22'd1000;
        c.short_press_min_ms = 16'd75;
        c.boot_grace_ms = 16'd8000;
        c.poll_step_ms = 10'd100;
        load_config(c);

        // field extremes on ignored words, and a poll while idle
        queue_word('0);
        queue_word('1);
        now_ms = 32'd20000;
        ev = build_event(OP_POLL, MODE_PERF, 1'b1, 1'b0);
        queue_word(ev);

        // arm on extreme readings, fire on the third step, hold stays up
        ev = build_event(OP_PRESS, MODE_SAVER, 1'b1, 1'b0);
        ev.smooth_reading = '1;
        ev.baseline_reading = 22'd1;
        ev.bench_reading = '1;
        queue_word(ev);
        repeat (4) begin
            now_ms += 32'd100;
            queue_word(build_event(OP_POLL, MODE_SAVER, 1'b1, 1'b0));
        end
        ev = build_event(OP_RELEASE, MODE_PROG, 1'b0, 1'b0);
        ev.calib_busy = 1'b0;
        queue_word(ev);

        // programming-mode tap of exactly the minimum length
        now_ms = 32'd30000;
        queue_word(build_event(OP_PRESS, MODE_PROG, 1'b0, 1'b0));
        now_ms = 32'd30075;
        ev = build_event(OP_RELEASE, MODE_PROG, 1'b0, 1'b0);
        ev.calib_busy = 1'b0;
        queue_word(ev);

        // invalid readings and zero baseline ask for recovery
        ev = build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0);
        ev.reading_valid = 1'b0;
        queue_word(ev);
        ev = build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0);
        ev.baseline_reading = '0;
        queue_word(ev);

        // poll in the unused mode aborts quietly
        queue_word(build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0));
        queue_word(build_event(OP_POLL, MODE_NONE, 1'b1, 1'b0));

        // unused mode press and release
        queue_word(build_event(OP_PRESS, MODE_NONE, 1'b1, 1'b0));
        queue_word(build_event(OP_RELEASE, MODE_NONE, 1'b1, 1'b0));

        // poll inside the boot grace period
        now_ms = 32'd100;
        queue_word(build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0));
        now_ms = 32'd200;
        queue_word(build_event(OP_POLL, MODE_PERF, 1'b1, 1'b0));

        // lost touch with a collapsed benchmark
        now_ms = 32'd40000;
        queue_word(build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0));
        queue_word(build_event(OP_POLL, MODE_PERF, 1'b0, 1'b1));

        // switch let go during polling
        queue_word(build_event(OP_PRESS, MODE_SAVER, 1'b1, 1'b0));
        ev = build_event(OP_POLL, MODE_SAVER, 1'b1, 1'b0);
        ev.switch_pressed = 1'b0;
        queue_word(ev);

        // release while calibration owns the pad
        queue_word(build_event(OP_PRESS, MODE_PERF, 1'b1, 1'b0));
        ev = build_event(OP_RELEASE, MODE_PROG, 1'b1, 1'b0);
        ev.calib_busy = 1'b1;
        queue_word(ev);

        // press duration across the time wrap
        now_ms = 32'hFFFF_FFF0;
        queue_word(build_event(OP_PRESS, MODE_PROG, 1'b0, 1'b0));
        now_ms = 32'd80;
        ev = build_event(OP_RELEASE, MODE_PROG, 1'b0, 1'b0);
        ev.calib_busy = 1'b0;
        queue_word(ev);

        // random phases, extremes first
        c.long_press_ms = '0;
        c.elev_threshold = '0;
        c.short_press_min_ms = '0;
        c.boot_grace_ms = '0;
        c.poll_step_ms = 10'd1;
        run_phase(c, 130, 1'b0, 1'b0);

        c.long_press_ms = '1;
        c.elev_threshold = '1;
        c.short_press_min_ms = '1;
        c.boot_grace_ms = '1;
        c.poll_step_ms = 10'd1000;
        run_phase(c, 80, 1'b0, 1'b0);

        c.elev_threshold = '0;
        c.boot_grace_ms = '0;
        run_phase(c, 160, 1'b1, 1'b0);

        run_phase(random_cfg(), 150, 1'b0, 1'b1);
        run_phase(random_cfg(), 150, 1'b0, 1'b0);

        // closing stretch with no idling on either side
        wait_idle();
        idle_on = 1'b0;
        run_phase(random_cfg(), 130, 1'b0, 1'b0);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (expected_levels.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
        if (error_count == 0)
            $display("tb_touch_long_press_qualifier: PASS");
        else
            $display("tb_touch_long_press_qualifier: FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_UNITS);
        $display("tb_touch_long_press_qualifier: FAIL");
        $finish;
    end

endmodule
